/* rtl/y4m_stream_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Y4M stream deframer assertion macros
// Clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef Y4M_STREAM_DEFRAMER_ASSERT_SVH
`define Y4M_STREAM_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define Y4MDF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define Y4MDF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/y4mdf_pkg.sv */
// ----------------------------------------------------------------------------
// y4mdf_pkg
// Shared types, codes and marker text for the Y4M stream deframer.
// ----------------------------------------------------------------------------
package y4mdf_pkg;

  localparam int MAX_DIMENSION_DEF = 16383;

  localparam int FIELD_DIM_W = 14;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } result_kind_t;

  typedef enum logic [3:0] {
    ERR_NO_MARKER    = 4'd0,
    ERR_BAD_TOKEN    = 4'd1,
    ERR_WIDTH        = 4'd2,
    ERR_HEIGHT       = 4'd3,
    ERR_CHROMA       = 4'd4,
    ERR_INTERLACED   = 4'd5,
    ERR_NO_WIDTH     = 4'd6,
    ERR_NO_HEIGHT    = 4'd7,
    ERR_NO_CHROMA    = 4'd8,
    ERR_ODD_SIZE     = 4'd9,
    ERR_FRAME        = 4'd10,
    ERR_SHORT_FRAME  = 4'd11,
    ERR_SHORT_HEADER = 4'd12
  } error_code_t;

  typedef enum logic [1:0] {
    CHROMA_NONE = 2'd0,
    CHROMA_420  = 2'd1,
    CHROMA_444  = 2'd2
  } chroma_t;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [3:0] SIG_LEN  = 4'd9;
  localparam logic [3:0] MARK_LEN = 4'd6;
  localparam logic [3:0] PEG_LEN  = 4'd3;

  function automatic logic [7:0] sig_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "Y";
      4'd1:    c = "U";
      4'd2:    c = "V";
      4'd3:    c = "4";
      4'd4:    c = "M";
      4'd5:    c = "P";
      4'd6:    c = "E";
      4'd7:    c = "G";
      4'd8:    c = "2";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mark_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "F";
      4'd1:    c = "R";
      4'd2:    c = "A";
      4'd3:    c = "M";
      4'd4:    c = "E";
      4'd5:    c = CHAR_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] peg_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "p";
      4'd1:    c = "e";
      4'd2:    c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/y4m_stream_deframer.sv */
// ----------------------------------------------------------------------------
// y4m_stream_deframer
// Byte-serial Y4M parser: header check, FRAME markers, tagged plane bytes.
//
//   channel  dir  handshake              payload
//   input    in   in_valid / in_ready    byte_value, new_file, stream_end
//   output   out  out_valid / out_ready  result_kind .. chroma_mode
//
// One byte is accepted per cycle while in_ready is high; its result, if
// any, sits in the output register in the cycle after the beat. The parse
// state and the output register are updated together, so throughput is set
// by that single register stage. in_ready is high while the output register
// is empty or being drained. rst is synchronous; no clearing pass follows it.
// ----------------------------------------------------------------------------
`include "y4m_stream_deframer_assert.svh"

module y4m_stream_deframer #(
  parameter int MAX_DIMENSION = y4mdf_pkg::MAX_DIMENSION_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        new_file,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [3:0]  error_code,
  output logic [7:0]  pixel_value,
  output logic [1:0]  plane,
  output logic [13:0] pixel_column,
  output logic [13:0] pixel_row,
  output logic        last_of_frame,
  output logic [13:0] frame_width,
  output logic [13:0] frame_height,
  output logic        chroma_mode
);

  import y4mdf_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int ACC_W = $clog2(MAX_DIMENSION + 2);
  localparam int MUL_W = ACC_W + 4;
  localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(MAX_DIMENSION + 1);
  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(MAX_DIMENSION);

  typedef enum logic [4:0] {
    PH_SIG  = 5'd0,
    PH_SEP  = 5'd1,
    PH_KEY  = 5'd2,
    PH_DIGW = 5'd3,
    PH_DIGH = 5'd4,
    PH_C    = 5'd5,
    PH_C4   = 5'd6,
    PH_C42  = 5'd7,
    PH_C44  = 5'd8,
    PH_C420 = 5'd9,
    PH_JPEG = 5'd10,
    PH_I    = 5'd11,
    PH_SKIP = 5'd12,
    PH_HERR = 5'd13,
    PH_MARK = 5'd14,
    PH_PIX  = 5'd15,
    PH_BADF = 5'd16,
    PH_IDLE = 5'd17
  } phase_t;

  typedef struct packed {
    result_kind_t kind;
    error_code_t  code;
    logic [7:0]   pixel;
    logic [1:0]   plane;
    logic [13:0]  column;
    logic [13:0]  row;
    logic         last;
    logic [13:0]  width;
    logic [13:0]  height;
    logic         mode;
  } result_t;

  phase_t           phase, phase_next;
  logic [3:0]       match_index, match_index_next;
  logic [ACC_W-1:0] digit_acc, digit_acc_next;
  logic [DIM_W-1:0] stored_width, stored_width_next;
  logic [DIM_W-1:0] stored_height, stored_height_next;
  chroma_t          stored_chroma, stored_chroma_next;
  logic [1:0]       cur_plane, cur_plane_next;
  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic             halted, halted_next;
  result_t          result, res;
  logic             res_valid;

  phase_t           e_phase;
  logic [3:0]       e_mi;
  logic [ACC_W-1:0] e_acc;
  logic [DIM_W-1:0] e_sw, e_sh, e_col, e_row;
  chroma_t          e_sc;
  logic [1:0]       e_plane;
  logic             e_halted;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W:0]   col_inc, row_inc;
  logic             col_wrap, row_wrap, adv_last;
  logic [DIM_W-1:0] adv_col, adv_row;
  logic [1:0]       adv_plane;

  logic [MUL_W-1:0] acc_mul;
  logic             is_digit;
  logic             fail, finish, err_fire;
  error_code_t      fail_code, err_code;
  logic             accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    e_phase  = new_file ? PH_SIG : phase;
    e_mi     = new_file ? 4'd0 : match_index;
    e_acc    = new_file ? '0 : digit_acc;
    e_sw     = new_file ? '0 : stored_width;
    e_sh     = new_file ? '0 : stored_height;
    e_sc     = new_file ? CHROMA_NONE : stored_chroma;
    e_plane  = new_file ? 2'd0 : cur_plane;
    e_col    = new_file ? '0 : column_count;
    e_row    = new_file ? '0 : row_count;
    e_halted = new_file ? 1'b0 : halted;
  end

  always_comb begin
    w_eff     = (e_plane != 2'd0 && e_sc == CHROMA_420) ? (e_sw >> 1) : e_sw;
    h_eff     = (e_plane != 2'd0 && e_sc == CHROMA_420) ? (e_sh >> 1) : e_sh;
    col_inc   = {1'b0, e_col} + (DIM_W+1)'(1);
    row_inc   = {1'b0, e_row} + (DIM_W+1)'(1);
    col_wrap  = col_inc >= {1'b0, w_eff};
    row_wrap  = row_inc >= {1'b0, h_eff};
    adv_last  = col_wrap && row_wrap && (e_plane == 2'd2);
    adv_col   = col_wrap ? '0 : col_inc[DIM_W-1:0];
    adv_row   = col_wrap ? (row_wrap ? '0 : row_inc[DIM_W-1:0]) : e_row;
    adv_plane = (col_wrap && row_wrap) ? ((e_plane == 2'd2) ? 2'd0 : e_plane + 2'd1)
                                       : e_plane;
  end

  always_comb begin
    is_digit = byte_value inside {["0":"9"]};
    acc_mul  = ({4'b0, e_acc} << 3) + ({4'b0, e_acc} << 1) + MUL_W'(byte_value[3:0]);
  end

  always_comb begin
    phase_next         = e_phase;
    match_index_next   = e_mi;
    digit_acc_next     = e_acc;
    stored_width_next  = e_sw;
    stored_height_next = e_sh;
    stored_chroma_next = e_sc;
    cur_plane_next     = e_plane;
    column_count_next  = e_col;
    row_count_next     = e_row;
    halted_next        = e_halted;
    res                = '0;
    res_valid          = 1'b0;
    fail               = 1'b0;
    fail_code          = ERR_NO_MARKER;
    finish             = 1'b0;
    err_fire           = 1'b0;
    err_code           = ERR_NO_MARKER;

    if (!e_halted) begin
      if (stream_end) begin
        if (e_phase == PH_IDLE) begin
          res_valid = 1'b0;
        end else if (e_phase == PH_MARK && e_mi == 4'd0) begin
          res_valid  = 1'b1;
          res.kind   = KIND_END;
          phase_next = PH_IDLE;
        end else if (e_phase == PH_MARK || e_phase == PH_PIX || e_phase == PH_BADF) begin
          err_fire = 1'b1;
          err_code = ERR_SHORT_FRAME;
        end else begin
          err_fire = 1'b1;
          err_code = ERR_SHORT_HEADER;
        end
      end else begin
        case (e_phase)
          PH_IDLE: begin
            res_valid = 1'b0;
          end
          PH_MARK: begin
            match_index_next  = e_mi + 4'd1;
            cur_plane_next    = 2'd0;
            column_count_next = '0;
            row_count_next    = '0;
            if (byte_value == mark_char(e_mi)) begin
              if (e_mi + 4'd1 >= MARK_LEN) phase_next = PH_PIX;
              else begin
                cur_plane_next    = e_plane;
                column_count_next = e_col;
                row_count_next    = e_row;
              end
            end else begin
              phase_next = PH_BADF;
            end
          end
          PH_PIX: begin
            res_valid         = 1'b1;
            res.kind          = KIND_PIXEL;
            res.pixel         = byte_value;
            res.plane         = e_plane;
            res.column        = 14'(e_col);
            res.row           = 14'(e_row);
            res.last          = adv_last;
            cur_plane_next    = adv_plane;
            column_count_next = adv_col;
            row_count_next    = adv_row;
            if (adv_last) begin
              phase_next       = PH_MARK;
              match_index_next = 4'd0;
            end
          end
          PH_BADF: begin
            if (e_mi < MARK_LEN) begin
              match_index_next = e_mi + 4'd1;
            end else begin
              cur_plane_next    = adv_plane;
              column_count_next = adv_col;
              row_count_next    = adv_row;
              if (adv_last) begin
                err_fire = 1'b1;
                err_code = ERR_FRAME;
              end
            end
          end
          PH_SIG: begin
            if (byte_value != sig_char(e_mi)) begin
              fail      = 1'b1;
              fail_code = ERR_NO_MARKER;
            end else begin
              match_index_next = e_mi + 4'd1;
              if (e_mi + 4'd1 >= SIG_LEN) phase_next = PH_SEP;
            end
          end
          PH_SEP, PH_C420, PH_DIGW, PH_DIGH: begin
            if ((e_phase == PH_DIGW || e_phase == PH_DIGH) && is_digit) begin
              digit_acc_next   = (acc_mul > MUL_W'(ACC_SAT)) ? ACC_SAT
                                                             : acc_mul[ACC_W-1:0];
              match_index_next = 4'd1;
            end else if ((e_phase == PH_DIGW || e_phase == PH_DIGH) &&
                         (e_mi == 4'd0 || e_acc == '0 || e_acc > ACC_MAX)) begin
              fail      = 1'b1;
              fail_code = (e_phase == PH_DIGW) ? ERR_WIDTH : ERR_HEIGHT;
            end else if (e_phase == PH_C420 && byte_value == "j") begin
              phase_next       = PH_JPEG;
              match_index_next = 4'd0;
            end else begin
              if (e_phase == PH_DIGW) stored_width_next = DIM_W'(e_acc);
              if (e_phase == PH_DIGH) stored_height_next = DIM_W'(e_acc);
              if (byte_value == CHAR_SPACE) phase_next = PH_KEY;
              else if (byte_value == CHAR_LF) finish = 1'b1;
              else begin
                fail      = 1'b1;
                fail_code = ERR_BAD_TOKEN;
              end
            end
          end
          PH_KEY: begin
            if (byte_value == CHAR_LF) begin
              err_fire = 1'b1;
              err_code = ERR_BAD_TOKEN;
            end else if (byte_value == "W" || byte_value == "H") begin
              phase_next       = (byte_value == "W") ? PH_DIGW : PH_DIGH;
              digit_acc_next   = '0;
              match_index_next = 4'd0;
            end else if (byte_value == "C") begin
              phase_next = PH_C;
            end else if (byte_value == "I") begin
              phase_next = PH_I;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_C: begin
            if (byte_value == "4") phase_next = PH_C4;
            else begin
              fail      = 1'b1;
              fail_code = ERR_CHROMA;
            end
          end
          PH_C4: begin
            if (byte_value == "2") phase_next = PH_C42;
            else if (byte_value == "4") phase_next = PH_C44;
            else begin
              fail      = 1'b1;
              fail_code = ERR_CHROMA;
            end
          end
          PH_C42: begin
            if (byte_value == "0") begin
              stored_chroma_next = CHROMA_420;
              phase_next         = PH_C420;
            end else begin
              fail      = 1'b1;
              fail_code = ERR_CHROMA;
            end
          end
          PH_C44: begin
            if (byte_value == "4") begin
              stored_chroma_next = CHROMA_444;
              phase_next         = PH_SEP;
            end else begin
              fail      = 1'b1;
              fail_code = ERR_CHROMA;
            end
          end
          PH_JPEG: begin
            if (byte_value != peg_char(e_mi)) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_TOKEN;
            end else begin
              match_index_next = e_mi + 4'd1;
              if (e_mi + 4'd1 >= PEG_LEN) phase_next = PH_SEP;
            end
          end
          PH_I: begin
            if (byte_value == "p") phase_next = PH_SEP;
            else begin
              fail      = 1'b1;
              fail_code = ERR_INTERLACED;
            end
          end
          PH_SKIP: begin
            if (byte_value == CHAR_SPACE) phase_next = PH_KEY;
            else if (byte_value == CHAR_LF) finish = 1'b1;
          end
          PH_HERR: begin
            if (byte_value == CHAR_LF) begin
              err_fire = 1'b1;
              err_code = error_code_t'(e_mi);
            end
          end
          default: begin
            phase_next = e_phase;
          end
        endcase
      end

      if (fail) begin
        if (byte_value == CHAR_LF) begin
          err_fire = 1'b1;
          err_code = fail_code;
        end else begin
          phase_next       = PH_HERR;
          match_index_next = fail_code;
        end
      end

      if (finish) begin
        if (stored_width_next == '0) begin
          err_fire = 1'b1;
          err_code = ERR_NO_WIDTH;
        end else if (stored_height_next == '0) begin
          err_fire = 1'b1;
          err_code = ERR_NO_HEIGHT;
        end else if (stored_chroma_next == CHROMA_NONE) begin
          err_fire = 1'b1;
          err_code = ERR_NO_CHROMA;
        end else if (stored_chroma_next == CHROMA_420 &&
                     (stored_width_next[0] || stored_height_next[0])) begin
          err_fire = 1'b1;
          err_code = ERR_ODD_SIZE;
        end else begin
          res_valid        = 1'b1;
          res.kind         = KIND_HEADER;
          res.width        = 14'(stored_width_next);
          res.height       = 14'(stored_height_next);
          res.mode         = (stored_chroma_next == CHROMA_444);
          phase_next       = PH_MARK;
          match_index_next = 4'd0;
        end
      end

      if (err_fire) begin
        res         = '0;
        res.kind    = KIND_ERROR;
        res.code    = err_code;
        res_valid   = 1'b1;
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIG;
      match_index   <= 4'd0;
      digit_acc     <= '0;
      stored_width  <= '0;
      stored_height <= '0;
      stored_chroma <= CHROMA_NONE;
      cur_plane     <= 2'd0;
      column_count  <= '0;
      row_count     <= '0;
      halted        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        match_index   <= match_index_next;
        digit_acc     <= digit_acc_next;
        stored_width  <= stored_width_next;
        stored_height <= stored_height_next;
        stored_chroma <= stored_chroma_next;
        cur_plane     <= cur_plane_next;
        column_count  <= column_count_next;
        row_count     <= row_count_next;
        halted        <= halted_next;
        out_valid     <= res_valid;
        if (res_valid) result <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_kind   = result.kind;
  assign error_code    = result.code;
  assign pixel_value   = result.pixel;
  assign plane         = result.plane;
  assign pixel_column  = result.column;
  assign pixel_row     = result.row;
  assign last_of_frame = result.last;
  assign frame_width   = result.width;
  assign frame_height  = result.height;
  assign chroma_mode   = result.mode;

  `Y4MDF_ASSERT_IMP(a_pix_plane, out_valid && result_kind == KIND_PIXEL, plane != 2'd3, "pixel plane out of range")
  `Y4MDF_ASSERT_IMP(a_code_zero, out_valid && result_kind != KIND_ERROR, error_code == ERR_NO_MARKER, "error code on non-error beat")
  `Y4MDF_ASSERT_IMP(a_hdr_dims, out_valid && result_kind == KIND_HEADER, frame_width != 14'd0 && frame_height != 14'd0, "header with zero size")
  `Y4MDF_ASSERT_NXT(a_halt_hold, halted && !(accept && new_file), halted, "halt released without new file")

endmodule

/* dv/y4m_stream_deframer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// y4m_stream_deframer_tb
// Feeds Y4M files byte by byte, well-formed ones with random sizes, tokens
// and samples as well as damaged, cut short and restarted ones, and checks
// every result beat against a parser model kept in step with accepted beats.
// ----------------------------------------------------------------------------
module y4m_stream_deframer_tb;
  import y4mdf_pkg::*;

  localparam int MAX_DIM = MAX_DIMENSION_DEF;
  localparam logic [8:0][7:0] SIG_TEXT  = "YUV4MPEG2";
  localparam logic [5:0][7:0] MARK_TEXT = "FRAME\n";
  localparam logic [2:0][7:0] PEG_TEXT  = "peg";
  localparam int TAIL_BEATS = 100;

  typedef enum logic [4:0] {
    PS_SIGNATURE, PS_SEPARATOR, PS_KEY, PS_WIDTH, PS_HEIGHT, PS_C, PS_C4, PS_C42,
    PS_C44, PS_C420, PS_JPEG, PS_INTERLACE, PS_SKIP, PS_HEADER_ERR, PS_MARKER,
    PS_PIXELS, PS_BAD_FRAME, PS_IDLE
  } parse_state_t;

  typedef struct packed {
    result_kind_t kind;
    error_code_t  code;
    logic [7:0]   value;
    logic [1:0]   plane;
    logic [13:0]  column;
    logic [13:0]  row;
    logic         last;
    logic [13:0]  width;
    logic [13:0]  height;
    logic         chroma;
  } deframe_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       file_start;
    logic       file_end;
  } file_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = '0;
  logic        new_file = 1'b0;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [3:0]  error_code;
  logic [7:0]  pixel_value;
  logic [1:0]  plane;
  logic [13:0] pixel_column;
  logic [13:0] pixel_row;
  logic        last_of_frame;
  logic [13:0] frame_width;
  logic [13:0] frame_height;
  logic        chroma_mode;

  y4m_stream_deframer dut (.*);

  always #2 clk = ~clk;

  parse_state_t    ps;
  logic [3:0]      ps_index;
  logic [14:0]     digits;
  logic [13:0]     hdr_width, hdr_height;
  chroma_t         hdr_chroma;
  logic [1:0]      cur_plane;
  logic [13:0]     cur_col, cur_row;
  logic            stopped;
  deframe_result_t res_word;

  deframe_result_t deframed_results[$];
  file_beat_t      file_beats[$];
  int              mismatches = 0;

  function automatic void restart_parse();
    ps = PS_SIGNATURE;
    ps_index = '0;
    digits = '0;
    hdr_width = '0;
    hdr_height = '0;
    hdr_chroma = CHROMA_NONE;
    cur_plane = '0;
    cur_col = '0;
    cur_row = '0;
    stopped = 1'b0;
  endfunction

  function automatic bit raise_error(error_code_t code);
    res_word = '0;
    res_word.kind = KIND_ERROR;
    res_word.code = code;
    stopped = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit hold_error(error_code_t code, logic [7:0] b);
    if (b == CHAR_LF) return raise_error(code);
    ps = PS_HEADER_ERR;
    ps_index = code;
    return 1'b0;
  endfunction

  function automatic bit close_header();
    if (hdr_width == 0) return raise_error(ERR_NO_WIDTH);
    if (hdr_height == 0) return raise_error(ERR_NO_HEIGHT);
    if (hdr_chroma == CHROMA_NONE) return raise_error(ERR_NO_CHROMA);
    if (hdr_chroma == CHROMA_420 && (hdr_width[0] | hdr_height[0]))
      return raise_error(ERR_ODD_SIZE);
    res_word = '0;
    res_word.kind = KIND_HEADER;
    res_word.width = hdr_width;
    res_word.height = hdr_height;
    res_word.chroma = (hdr_chroma == CHROMA_444);
    ps = PS_MARKER;
    ps_index = '0;
    return 1'b1;
  endfunction

  function automatic bit end_token(logic [7:0] b);
    if (b == CHAR_SPACE) begin
      ps = PS_KEY;
      return 1'b0;
    end
    if (b == CHAR_LF) return close_header();
    return hold_error(ERR_BAD_TOKEN, b);
  endfunction

  function automatic bit step_position();
    logic [13:0] w, h;
    w = hdr_width;
    h = hdr_height;
    if (cur_plane != 0 && hdr_chroma == CHROMA_420) begin
      w = w >> 1;
      h = h >> 1;
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = '0;
      cur_row++;
      if (cur_row >= h) begin
        cur_row = '0;
        cur_plane++;
        if (cur_plane >= 2'd3) begin
          cur_plane = '0;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit deframe_byte(logic [7:0] b, logic restart, logic ended);
    logic [1:0]  p;
    logic [13:0] c, r;
    logic        fin;
    int          acc;
    if (restart) restart_parse();
    if (stopped) return 1'b0;
    if (ended) begin
      if (ps == PS_IDLE) return 1'b0;
      if (ps == PS_MARKER && ps_index == 0) begin
        res_word = '0;
        res_word.kind = KIND_END;
        ps = PS_IDLE;
        return 1'b1;
      end
      if (ps == PS_MARKER || ps == PS_PIXELS || ps == PS_BAD_FRAME)
        return raise_error(ERR_SHORT_FRAME);
      return raise_error(ERR_SHORT_HEADER);
    end
    case (ps)
      PS_IDLE: return 1'b0;
      PS_MARKER: begin
        if (b != MARK_TEXT[MARK_LEN - 4'd1 - ps_index]) ps = PS_BAD_FRAME;
        else if (ps_index == MARK_LEN - 4'd1) ps = PS_PIXELS;
        ps_index++;
        if (ps != PS_MARKER) begin
          cur_plane = '0;
          cur_col = '0;
          cur_row = '0;
        end
        return 1'b0;
      end
      PS_PIXELS: begin
        p = cur_plane;
        c = cur_col;
        r = cur_row;
        fin = step_position();
        res_word = '0;
        res_word.kind = KIND_PIXEL;
        res_word.value = b;
        res_word.plane = p;
        res_word.column = c;
        res_word.row = r;
        res_word.last = fin;
        if (fin) begin
          ps = PS_MARKER;
          ps_index = '0;
        end
        return 1'b1;
      end
      PS_BAD_FRAME: begin
        if (ps_index < MARK_LEN) begin
          ps_index++;
          return 1'b0;
        end
        if (step_position()) return raise_error(ERR_FRAME);
        return 1'b0;
      end
      PS_SIGNATURE: begin
        if (b != SIG_TEXT[SIG_LEN - 4'd1 - ps_index]) return hold_error(ERR_NO_MARKER, b);
        ps_index++;
        if (ps_index >= SIG_LEN) ps = PS_SEPARATOR;
        return 1'b0;
      end
      PS_SEPARATOR: return end_token(b);
      PS_KEY: begin
        if (b == CHAR_LF) return raise_error(ERR_BAD_TOKEN);
        if (b == "W" || b == "H") begin
          ps = (b == "W") ? PS_WIDTH : PS_HEIGHT;
          digits = '0;
          ps_index = '0;
        end else if (b == "C") begin
          ps = PS_C;
        end else if (b == "I") begin
          ps = PS_INTERLACE;
        end else begin
          ps = PS_SKIP;
        end
        return 1'b0;
      end
      PS_WIDTH, PS_HEIGHT: begin
        if (b >= "0" && b <= "9") begin
          acc = int'(digits) * 10 + int'(b - "0");
          if (acc > MAX_DIM + 1) acc = MAX_DIM + 1;
          digits = 15'(acc);
          ps_index = 4'd1;
          return 1'b0;
        end
        if (ps_index == 0 || digits == 0 || int'(digits) > MAX_DIM)
          return hold_error((ps == PS_WIDTH) ? ERR_WIDTH : ERR_HEIGHT, b);
        if (ps == PS_WIDTH) hdr_width = 14'(digits);
        else hdr_height = 14'(digits);
        return end_token(b);
      end
      PS_C: begin
        if (b == "4") begin
          ps = PS_C4;
          return 1'b0;
        end
        return hold_error(ERR_CHROMA, b);
      end
      PS_C4: begin
        if (b == "2") begin
          ps = PS_C42;
          return 1'b0;
        end
        if (b == "4") begin
          ps = PS_C44;
          return 1'b0;
        end
        return hold_error(ERR_CHROMA, b);
      end
      PS_C42: begin
        if (b == "0") begin
          hdr_chroma = CHROMA_420;
          ps = PS_C420;
          return 1'b0;
        end
        return hold_error(ERR_CHROMA, b);
      end
      PS_C44: begin
        if (b == "4") begin
          hdr_chroma = CHROMA_444;
          ps = PS_SEPARATOR;
          return 1'b0;
        end
        return hold_error(ERR_CHROMA, b);
      end
      PS_C420: begin
        if (b == "j") begin
          ps = PS_JPEG;
          ps_index = '0;
          return 1'b0;
        end
        return end_token(b);
      end
      PS_JPEG: begin
        if (b != PEG_TEXT[PEG_LEN - 4'd1 - ps_index]) return hold_error(ERR_BAD_TOKEN, b);
        ps_index++;
        if (ps_index >= PEG_LEN) ps = PS_SEPARATOR;
        return 1'b0;
      end
      PS_INTERLACE: begin
        if (b == "p") begin
          ps = PS_SEPARATOR;
          return 1'b0;
        end
        return hold_error(ERR_INTERLACED, b);
      end
      PS_SKIP: begin
        if (b == CHAR_SPACE) begin
          ps = PS_KEY;
          return 1'b0;
        end
        if (b == CHAR_LF) return close_header();
        return 1'b0;
      end
      default: begin
        if (b == CHAR_LF) return raise_error(error_code_t'(ps_index));
        return 1'b0;
      end
    endcase
  endfunction

  task automatic push_beat(logic [7:0] v, logic start, logic ended);
    file_beat_t bt;
    bt.data = v;
    bt.file_start = start;
    bt.file_end = ended;
    file_beats.insert(file_beats.size(), bt);
  endtask

  task automatic push_text(string s, bit start);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], start && i == 0, 1'b0);
  endtask

  function automatic string broken_token(int field);
    case (field)
      0: case ($urandom_range(0, 5))
        0: return "W";
        1: return "W0";
        2: return "W16384";
        3: return "W99999";
        4: return "W16383";
        default: return "Wx2";
      endcase
      1: case ($urandom_range(0, 5))
        0: return "H";
        1: return "H0";
        2: return "H16384";
        3: return "H123456";
        4: return "H16383";
        default: return "H2x";
      endcase
      2: case ($urandom_range(0, 9))
        0: return "C";
        1: return "C4";
        2: return "C42";
        3: return "C422";
        4: return "C4444";
        5: return "C420j";
        6: return "C420jpx";
        7: return "C420p";
        8: return "C444alpha";
        default: return "Cmono";
      endcase
      default: case ($urandom_range(0, 3))
        0: return "It";
        1: return "Ib";
        2: return "I";
        default: return "Ipx";
      endcase
    endcase
  endfunction

  task automatic make_file();
    string      tokens[$];
    string      hdr, tmp;
    logic [7:0] file_bytes[$];
    int         w, h, mode, nframes, npix, fault, pos, j;
    fault = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 15) : 0;
    if (fault == 15) begin
      pos = $urandom_range(1, 8);
      for (int i = 0; i < pos; i++)
        push_beat(($urandom_range(0, 2) == 0) ? 8'("Y") : 8'($urandom), i == 0, 1'b0);
      push_beat(8'($urandom), 1'b0, 1'b1);
      return;
    end
    mode = $urandom_range(0, 2);
    w = (mode == 2) ? $urandom_range(1, 4) : 2 * $urandom_range(1, 2);
    h = (mode == 2) ? $urandom_range(1, 4) : 2 * $urandom_range(1, 2);
    tokens.insert(tokens.size(), $sformatf("W%0d", w));
    tokens.insert(tokens.size(), $sformatf("H%0d", h));
    if (mode == 0) tmp = "C420jpeg";
    else if (mode == 1) tmp = "C420";
    else tmp = "C444";
    tokens.insert(tokens.size(), tmp);
    if ($urandom_range(0, 1) == 0) tokens.insert(tokens.size(), "Ip");
    if ($urandom_range(0, 3) == 0) tokens.insert(tokens.size(), "F30000:1001");
    if ($urandom_range(0, 3) == 0) tokens.insert(tokens.size(), "XYSCSS=420JPEG");
    case (fault)
      1: tokens.delete($urandom_range(0, 2));
      2, 3, 4: tokens[fault - 2] = broken_token(fault - 2);
      5: tokens.insert(tokens.size(), broken_token(3));
      6: begin
        tokens[2] = "C420";
        tokens[$urandom_range(0, 1)] = ($urandom_range(0, 1) == 0) ? "W3" : "H5";
      end
      7: tokens.insert(tokens.size(), "");
      default: ;
    endcase
    for (int i = tokens.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = tokens[i];
      tokens[i] = tokens[j];
      tokens[j] = tmp;
    end
    hdr = "YUV4MPEG2";
    foreach (tokens[i]) hdr = {hdr, " ", tokens[i]};
    hdr = {hdr, "\n"};
    for (int i = 0; i < hdr.len(); i++) file_bytes.insert(file_bytes.size(), hdr[i]);
    nframes = $urandom_range(0, 2);
    npix = (mode == 2) ? 3 * w * h : w * h + 2 * (w / 2) * (h / 2);
    repeat (nframes) begin
      for (int k = 5; k >= 0; k--) file_bytes.insert(file_bytes.size(), MARK_TEXT[k]);
      repeat (npix) file_bytes.insert(file_bytes.size(), 8'($urandom));
    end
    case (fault)
      8: file_bytes[$urandom_range(0, hdr.len() - 1)] = 8'($urandom);
      9: if (nframes > 0) file_bytes[hdr.len() + $urandom_range(0, 5)] = 8'($urandom);
      10, 11: begin
        pos = (fault == 10) ? $urandom_range(1, file_bytes.size()) :
                              $urandom_range(1, hdr.len() - 1);
        while (file_bytes.size() > pos) void'(file_bytes.pop_back());
      end
      default: ;
    endcase
    foreach (file_bytes[i]) push_beat(file_bytes[i], i == 0, 1'b0);
    case (fault)
      12: ;
      13: push_beat(8'($urandom), 1'b1, 1'b1);
      14: begin
        push_beat(8'($urandom), 1'b0, 1'b1);
        push_beat(8'($urandom), 1'b0, 1'b1);
        repeat (3) push_beat(8'($urandom), 1'b0, 1'b0);
      end
      default: push_beat(8'($urandom), 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // input side
  int         gap_left = 0;
  int         in_calm = 0;
  file_beat_t next_beat;

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        if (deframe_byte(byte_value, new_file, stream_end))
          deframed_results.insert(deframed_results.size(), res_word);
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 63) == 0) in_calm = $urandom_range(20, 120);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (file_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (file_beats.size() > TAIL_BEATS && in_calm == 0 &&
                     $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          next_beat = file_beats.pop_front();
          byte_value <= next_beat.data;
          new_file <= next_beat.file_start;
          stream_end <= next_beat.file_end;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // output side
  int              stall_left = 0;
  int              out_calm = 0;
  deframe_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframed_results.size() == 0) begin
          mismatches++;
          $display("%0t: result_kind expected none actual %0d", $time, result_kind);
        end else begin
          want = deframed_results.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("error_code", want.code, error_code);
          check_field("pixel_value", want.value, pixel_value);
          check_field("plane", want.plane, plane);
          check_field("pixel_column", want.column, pixel_column);
          check_field("pixel_row", want.row, pixel_row);
          check_field("last_of_frame", want.last, last_of_frame);
          check_field("frame_width", want.width, frame_width);
          check_field("frame_height", want.height, frame_height);
          check_field("chroma_mode", want.chroma, chroma_mode);
        end
      end
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 63) == 0) out_calm = $urandom_range(20, 120);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (file_beats.size() > TAIL_BEATS && out_calm == 0 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    push_text("YUV4MPEG2 W1 H1 C444\nFRAME\n", 1'b1);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h55, 1'b0, 1'b1);
    push_beat(8'hAA, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b1);
    push_text("Q\n", 1'b1);
    while (file_beats.size() < 1150) make_file();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (file_beats.size() != 0 || in_valid || deframed_results.size() != 0);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && deframed_results.size() == 0) begin
      $display("y4m_stream_deframer_tb passed");
    end else begin
      $display("y4m_stream_deframer_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("y4m_stream_deframer_tb failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/y4mdf_pkg.sv
rtl/y4m_stream_deframer.sv
dv/y4m_stream_deframer_tb.sv
